[rtl/core/dtpc_pkg.sv]
// Package for the dual tachometer period capture unit.
// Holds the widths, reset values, codes and structs used by every file;
// it depends on nothing.
package dtpc_pkg;

   localparam int CHANNELS   = 2;
   localparam int TIMER_BITS = 16;
   localparam int TIME_W     = 32;
   localparam int WRAP_W     = 17;
   localparam int LIMIT_W    = 16;
   localparam int CHAN_W     = 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0]  MIN_PULSE_RESET   = TIME_W'(5000);
   localparam logic [LIMIT_W-1:0] STALL_LIMIT_RESET = LIMIT_W'(1000);

   // Kinds of request transaction.
   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_CAPTURE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STALL_LIMIT = CSR_IDX_W'(1);

   // Command from the top level to one channel for the transaction in flight.
   typedef struct packed {
      logic                  tick;
      logic                  capture;
      logic                  rising;
      logic [TIMER_BITS-1:0] raw;
   } chan_cmd_type;

   // State of one channel as it stands after that transaction.
   typedef struct packed {
      logic [TIME_W-1:0] period;
      logic              stopped;
      logic              updated;
   } chan_stat_type;

endpackage

[rtl/core/dtpc_chan.sv]
// Per-channel state and its update for one tick or capture.
// Depends on dtpc_pkg for the widths and the command and status structs.
module dtpc_chan (
   input  logic                               clock,
   input  logic                               reset,
   input  dtpc_pkg::chan_cmd_type             cmd,
   input  logic [dtpc_pkg::TIME_W-1:0]        min_pulse,
   input  logic [dtpc_pkg::LIMIT_W-1:0]       stall_limit,
   output dtpc_pkg::chan_stat_type            stat
);
   import dtpc_pkg::*;

   logic [WRAP_W-1:0]     wrap_ff,   wrap_in;
   logic [TIME_W-1:0]     fall_ff,   fall_in;
   logic [TIMER_BITS-1:0] last_ff,   last_in;
   logic [TIME_W-1:0]     period_ff, period_in;
   logic                  stop_ff,   stop_in;
   logic [TIME_W-1:0]     ext_time;
   logic [TIME_W-1:0]     since_fall;
   logic                  accept;

   // The wrap count weighs 2^TIMER_BITS ticks; bits above 32 fall away.
   assign ext_time   = TIME_W'({wrap_ff, {TIMER_BITS{1'b0}}}) + TIME_W'(cmd.raw);
   assign since_fall = ext_time - fall_ff;
   assign accept     = cmd.capture && cmd.rising && (since_fall > min_pulse);

   always_comb begin
      wrap_in   = wrap_ff;
      fall_in   = fall_ff;
      last_in   = last_ff;
      period_in = period_ff;
      stop_in   = stop_ff;
      if (cmd.tick) begin
         if (wrap_ff > WRAP_W'(stall_limit)) begin
            stop_in   = 1'b1;
            last_in   = '0;
            fall_in   = '0;
            period_in = '0;
         end else begin
            wrap_in = wrap_ff + WRAP_W'(1);
         end
      end else if (cmd.capture) begin
         if (accept) begin
            period_in = ext_time - TIME_W'(last_ff);
            last_in   = cmd.raw;
            wrap_in   = '0;
            fall_in   = '0;
            stop_in   = 1'b0;
         end else if (!cmd.rising) begin
            fall_in = ext_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff   <= '0;
         fall_ff   <= '0;
         last_ff   <= '0;
         period_ff <= '0;
         stop_ff   <= 1'b1;
      end else begin
         wrap_ff   <= wrap_in;
         fall_ff   <= fall_in;
         last_ff   <= last_in;
         period_ff <= period_in;
         stop_ff   <= stop_in;
      end
   end

   assign stat.period  = period_in;
   assign stat.stopped = stop_in;
   assign stat.updated = accept;

endmodule

[rtl/core/dual_tacho_period_capture_unit.sv]
// Top level of the dual tachometer period capture unit.
// Depends on dtpc_pkg and instantiates one dtpc_chan for each channel.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    type, channel, capture time, level
//   rsp      out        rsp_valid/stall    channel, period, updated, stop flags
//   csr      in         csr_write_en       index, write data
//
// Each transaction is registered at the input and then updates the channel state
// and loads the result register, which drives the response. One transaction per
// cycle is sustained while the response is not stalled. The channel state update
// is the only loop. Reset is synchronous and leaves both channels stopped with
// the configuration at its default. A stalled response holds the result register
// and then the input register, so the stall reaches req_stall in the same cycle.
module dual_tacho_period_capture_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [dtpc_pkg::CHAN_W-1:0]          req_channel,
   input  logic [dtpc_pkg::TIMER_BITS-1:0]      req_capture_time,
   input  logic                                 req_level_high,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dtpc_pkg::CHAN_W-1:0]          rsp_out_channel,
   output logic [dtpc_pkg::TIME_W-1:0]          rsp_period_ticks,
   output logic                                 rsp_period_updated,
   output logic                                 rsp_stopped_zero,
   output logic                                 rsp_stopped_one,
   input  logic                                 csr_write_en,
   input  logic [dtpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dtpc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import dtpc_pkg::*;

   logic                  min_pulse_wr,    stall_limit_wr;
   logic [TIME_W-1:0]     min_pulse_ff;
   logic [LIMIT_W-1:0]    stall_limit_ff;

   logic                  in_valid_ff;
   logic                  in_type_ff;
   logic [CHAN_W-1:0]     in_channel_ff;
   logic [TIMER_BITS-1:0] in_time_ff;
   logic                  in_level_ff;

   logic                  out_valid_ff,   out_valid_in;
   logic [CHAN_W-1:0]     out_channel_ff;
   logic [TIME_W-1:0]     out_period_ff;
   logic                  out_updated_ff;
   logic                  out_stop0_ff;
   logic                  out_stop1_ff;

   logic                  advance;
   logic                  req_take;
   chan_cmd_type          cmd  [CHANNELS];
   chan_stat_type         stat [CHANNELS];

   always_comb begin
      min_pulse_wr   = 1'b0;
      stall_limit_wr = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MIN_PULSE:   min_pulse_wr   = 1'b1;
            CSR_STALL_LIMIT: stall_limit_wr = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff   <= MIN_PULSE_RESET;
         stall_limit_ff <= STALL_LIMIT_RESET;
      end else begin
         if (min_pulse_wr) begin
            min_pulse_ff <= TIME_W'(csr_wdata);
         end
         if (stall_limit_wr) begin
            stall_limit_ff <= csr_wdata[LIMIT_W-1:0];
         end
      end
   end

   // The held transaction moves on whenever the result register is free or
   // being emptied in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff    <= req_type;
         in_channel_ff <= req_channel;
         in_time_ff    <= req_capture_time;
         in_level_ff   <= req_level_high;
      end
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      assign cmd[c].tick    = advance && (in_type_ff == REQ_TICK);
      assign cmd[c].capture = advance && (in_type_ff == REQ_CAPTURE)
                              && (in_channel_ff == CHAN_W'(c));
      assign cmd[c].rising  = in_level_ff;
      assign cmd[c].raw     = in_time_ff;

      dtpc_chan u_chan (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd[c]),
         .min_pulse   (min_pulse_ff),
         .stall_limit (stall_limit_ff),
         .stat        (stat[c])
      );
   end

   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_channel_ff <= in_channel_ff;
         out_period_ff  <= stat[in_channel_ff].period;
         out_updated_ff <= stat[in_channel_ff].updated;
         out_stop0_ff   <= stat[0].stopped;
         out_stop1_ff   <= stat[1].stopped;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_channel    = out_channel_ff;
   assign rsp_period_ticks   = out_period_ff;
   assign rsp_period_updated = out_updated_ff;
   assign rsp_stopped_zero   = out_stop0_ff;
   assign rsp_stopped_one    = out_stop1_ff;

endmodule

[rtl/core/dtpc_checker.sv]
// Port-level checks for the dual tachometer period capture unit, with the
// bind that attaches them to the top level. Depends on dtpc_pkg.
module dtpc_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [dtpc_pkg::CHAN_W-1:0]          rsp_out_channel,
   input  logic [dtpc_pkg::TIME_W-1:0]          rsp_period_ticks,
   input  logic                                 rsp_period_updated,
   input  logic                                 rsp_stopped_zero,
   input  logic                                 rsp_stopped_one
);
   import dtpc_pkg::*;

   // No transaction is left in the result register by reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_period_ticks))
      else $error("stalled response dropped or changed");

   // An accepted rising edge always leaves its channel running.
   a_update_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_period_updated |->
         ((rsp_out_channel == CHAN_W'(0)) && !rsp_stopped_zero) ||
         ((rsp_out_channel == CHAN_W'(1)) && !rsp_stopped_one))
      else $error("updated period on a stopped channel");

   // A stopped channel has had its period cleared or never measured one.
   a_stopped_zero_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_channel == CHAN_W'(0)) && rsp_stopped_zero
         |-> rsp_period_ticks == '0)
      else $error("stopped channel 0 reports a period");

   a_stopped_one_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_channel == CHAN_W'(1)) && rsp_stopped_one
         |-> rsp_period_ticks == '0)
      else $error("stopped channel 1 reports a period");

endmodule

bind dual_tacho_period_capture_unit dtpc_checker u_dtpc_checker (.*);

[test/tacho_scoreboard_pkg.sv]
// Scoreboard for the dual tachometer period capture unit testbench: a
// transaction-level prediction of both channels and the queue of expected responses.
// Depends on dtpc_pkg for widths, reset values and codes.
package tacho_scoreboard_pkg;
   import dtpc_pkg::*;

   localparam logic LEVEL_FALLING = 1'b0;
   localparam logic LEVEL_RISING  = 1'b1;
   localparam int   REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [TIME_W-1:0] period;
      logic              updated;
      logic              stopped_zero;
      logic              stopped_one;
   } tacho_result_type;

   class tacho_scoreboard_type;
      logic [TIME_W-1:0]     min_pulse;
      logic [LIMIT_W-1:0]    stall_limit;
      logic [WRAP_W-1:0]     wraps    [CHANNELS];
      logic [TIME_W-1:0]     rise_at  [CHANNELS];
      logic [TIME_W-1:0]     fall_at  [CHANNELS];
      logic [TIMER_BITS-1:0] last_raw [CHANNELS];
      logic [TIME_W-1:0]     period   [CHANNELS];
      logic                  stopped  [CHANNELS];
      tacho_result_type      expected_results[$];
      int unsigned           request_count;
      int unsigned           result_count;
      int unsigned           update_count;
      int unsigned           stop_count;
      int unsigned           mismatch_count;

      function new();
         min_pulse   = MIN_PULSE_RESET;
         stall_limit = STALL_LIMIT_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            wraps[c]    = '0;
            rise_at[c]  = '0;
            fall_at[c]  = '0;
            last_raw[c] = '0;
            period[c]   = '0;
            stopped[c]  = 1'b1;
         end
         request_count  = 0;
         result_count   = 0;
         update_count   = 0;
         stop_count     = 0;
         mismatch_count = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_MIN_PULSE:   min_pulse   = data[TIME_W-1:0];
            CSR_STALL_LIMIT: stall_limit = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // The wrap count is 17 bits wide, so its top bit falls off the 32-bit time.
      function logic [TIME_W-1:0] extended_time(int c, logic [TIMER_BITS-1:0] raw);
         return (TIME_W'(wraps[c]) << TIMER_BITS) + TIME_W'(raw);
      endfunction

      function void note_request(logic kind, logic [CHAN_W-1:0] ch,
                                 logic [TIMER_BITS-1:0] raw, logic level);
         tacho_result_type  want;
         logic [TIME_W-1:0] ext;
         logic [TIME_W-1:0] since_fall;
         int                c;
         want.updated = 1'b0;
         if (kind == REQ_TICK) begin
            for (c = 0; c < CHANNELS; c++) begin
               if (wraps[c] > WRAP_W'(stall_limit)) begin
                  if (!stopped[c])
                     stop_count++;
                  stopped[c]  = 1'b1;
                  last_raw[c] = '0;
                  rise_at[c]  = '0;
                  fall_at[c]  = '0;
                  period[c]   = '0;
               end else begin
                  wraps[c] = wraps[c] + 1'b1;
               end
            end
         end else begin
            c   = int'(ch);
            ext = extended_time(c, raw);
            if (level == LEVEL_RISING) begin
               // A rejected rising edge still leaves its time behind.
               rise_at[c] = ext;
               since_fall = ext - fall_at[c];
               if (since_fall > min_pulse) begin
                  period[c]    = ext - TIME_W'(last_raw[c]);
                  last_raw[c]  = raw;
                  wraps[c]     = '0;
                  rise_at[c]   = '0;
                  fall_at[c]   = '0;
                  stopped[c]   = 1'b0;
                  want.updated = 1'b1;
                  update_count++;
               end
            end else begin
               fall_at[c] = ext;
            end
         end
         want.channel      = ch;
         want.period       = period[int'(ch)];
         want.stopped_zero = stopped[0];
         want.stopped_one  = stopped[1];
         expected_results.push_back(want);
         request_count++;
      endfunction

      function void check_result(tacho_result_type got);
         tacho_result_type want;
         result_count++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("response %0d with nothing expected: ch %0d period %h upd %b stop %b%b",
                        result_count, got.channel, got.period, got.updated,
                        got.stopped_one, got.stopped_zero);
            return;
         end
         want = expected_results.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("response %0d differs (expected / actual):", result_count);
               $display("  channel %0d / %0d, period %h / %h, updated %b / %b",
                        want.channel, got.channel, want.period, got.period,
                        want.updated, got.updated);
               $display("  stopped zero %b / %b, stopped one %b / %b",
                        want.stopped_zero, got.stopped_zero,
                        want.stopped_one, got.stopped_one);
            end
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

endpackage

[test/tb_top.sv]
// Testbench top for the dual tachometer period capture unit: drives ticks and
// edge captures under random idling and stalls and checks every response.
// Depends on dtpc_pkg, tacho_scoreboard_pkg and the unit's RTL.
module tb_top;
   import dtpc_pkg::*;
   import tacho_scoreboard_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 500000;
   localparam int          LONG_HOLD_CYCLES = 300;
   localparam int unsigned LONG_HOLD_AFTER  = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_type = REQ_TICK;
   logic [CHAN_W-1:0]     req_channel = '0;
   logic [TIMER_BITS-1:0] req_capture_time = '0;
   logic                  req_level_high = LEVEL_FALLING;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAN_W-1:0]     rsp_out_channel;
   logic [TIME_W-1:0]     rsp_period_ticks;
   logic                  rsp_period_updated;
   logic                  rsp_stopped_zero;
   logic                  rsp_stopped_one;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MIN_PULSE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tacho_scoreboard_type  board = new();
   tacho_result_type      observed_result;
   int unsigned           cycle_count = 0;
   int                    stall_run = 0;
   bit                    long_hold_done = 1'b0;
   int                    burst_left = 0;
   logic [TIMER_BITS-1:0] last_time  [CHANNELS];
   logic                  next_level [CHANNELS];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   dual_tacho_period_capture_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_channel        (req_channel),
      .req_capture_time   (req_capture_time),
      .req_level_high     (req_level_high),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_period_ticks   (rsp_period_ticks),
      .rsp_period_updated (rsp_period_updated),
      .rsp_stopped_zero   (rsp_stopped_zero),
      .rsp_stopped_one    (rsp_stopped_one),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   assign observed_result = {rsp_out_channel, rsp_period_ticks, rsp_period_updated,
                             rsp_stopped_zero, rsp_stopped_one};

   // The request is noted before the response is checked, though the pipeline
   // never lets a transaction's own response appear in the same cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_request(req_type, req_channel, req_capture_time, req_level_high);
         if (rsp_valid && !rsp_stall)
            board.check_result(observed_result);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run abandoned after %0d cycles", cycle_count);
         $display("dual_tacho_period_capture_unit: mismatch");
         $finish;
      end
   end

   // Receiver: runs of free cycles, short stalls and the odd long one. Once the
   // sender is well under way it holds off long enough for the unit to back up.
   always @(negedge clock) begin : receiver
      int pick;
      if (!long_hold_done && board.request_count >= LONG_HOLD_AFTER) begin
         long_hold_done <= 1'b1;
         stall_run      <= LONG_HOLD_CYCLES - 1;
         rsp_stall      <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(0, 40);
         end else if (pick < 90) begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(10, 60);
         end
      end
   end

   task automatic send_request(logic kind, logic [CHAN_W-1:0] ch,
                               logic [TIMER_BITS-1:0] raw, logic level);
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_channel      <= ch;
      req_capture_time <= raw;
      req_level_high   <= level;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   task automatic sender_idle();
      int pick;
      int gap;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 15)
            burst_left = $urandom_range(10, 50);
         else if (pick >= 92)
            gap = $urandom_range(8, 30);
         else if (pick >= 55)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      board.write_register(index, data);
   endtask

   // Mostly alternating falling and rising edges per channel, with rising edges
   // placed around the minimum pulse width; ticks, tick bursts and noise mixed in.
   task automatic send_random_item(int unsigned burst_max);
      int                    pick;
      int                    n;
      logic [CHAN_W-1:0]     ch;
      logic [TIMER_BITS-1:0] raw;
      logic                  level;
      pick = $urandom_range(0, 99);
      ch   = CHAN_W'($urandom_range(0, CHANNELS - 1));
      if (pick < 6) begin
         n = $urandom_range(1, burst_max);
         repeat (n) begin
            send_request(REQ_TICK, CHAN_W'($urandom), TIMER_BITS'($urandom), 1'($urandom));
            sender_idle();
         end
      end else if (pick < 20) begin
         send_request(REQ_TICK, ch, TIMER_BITS'($urandom), 1'($urandom));
         sender_idle();
      end else if (pick < 26) begin
         send_request(REQ_CAPTURE, ch, TIMER_BITS'($urandom), 1'($urandom));
         sender_idle();
      end else begin
         level = next_level[ch];
         if (level == LEVEL_FALLING) begin
            if ($urandom_range(0, 1) == 0)
               raw = TIMER_BITS'($urandom);
            else
               raw = last_time[ch] + TIMER_BITS'($urandom_range(0, 3000));
         end else begin
            case ($urandom_range(0, 2))
               0: raw = last_time[ch] + TIMER_BITS'($urandom_range(0, 40));
               1: raw = last_time[ch] + board.min_pulse[TIMER_BITS-1:0]
                        + TIMER_BITS'($urandom_range(0, 6)) - TIMER_BITS'(3);
               default: raw = TIMER_BITS'($urandom);
            endcase
         end
         send_request(REQ_CAPTURE, ch, raw, level);
         last_time[ch]  = raw;
         next_level[ch] = ~level;
         sender_idle();
      end
   endtask

   task automatic run_phase(logic [TIME_W-1:0] min_pulse, logic [LIMIT_W-1:0] limit,
                            int unsigned items);
      int unsigned target;
      int unsigned burst_max;
      write_register(CSR_MIN_PULSE, CSR_DATA_W'(min_pulse));
      write_register(CSR_STALL_LIMIT, CSR_DATA_W'(limit));
      burst_max = (limit < 9) ? int'(limit) + 3 : 12;
      target    = board.request_count + items;
      while (board.request_count < target)
         send_random_item(burst_max);
      wait_drained();
   endtask

   initial begin : stimulus
      for (int c = 0; c < CHANNELS; c++) begin
         last_time[c]  = '0;
         next_level[c] = LEVEL_FALLING;
      end
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset configuration: ticks naming either channel,
      // acceptance and rejection against the minimum pulse width, wraps in the
      // extended time, a rising edge that lands before its falling edge, and
      // the extremes of the capture time.
      send_request(REQ_TICK, 1'b0, 16'h0000, LEVEL_FALLING);
      send_request(REQ_TICK, 1'b1, 16'hFFFF, LEVEL_RISING);
      send_request(REQ_CAPTURE, 1'b0, 16'h0000, LEVEL_FALLING);
      send_request(REQ_CAPTURE, 1'b0, 16'hFFFF, LEVEL_RISING);
      sender_idle();
      send_request(REQ_CAPTURE, 1'b1, 16'd100, LEVEL_RISING);
      send_request(REQ_CAPTURE, 1'b1, 16'd200, LEVEL_RISING);
      send_request(REQ_CAPTURE, 1'b1, 16'hFFFF, LEVEL_FALLING);
      send_request(REQ_TICK, 1'b1, 16'h0000, LEVEL_FALLING);
      send_request(REQ_CAPTURE, 1'b1, 16'h1234, LEVEL_RISING);
      send_request(REQ_CAPTURE, 1'b1, 16'h2000, LEVEL_RISING);
      sender_idle();
      send_request(REQ_CAPTURE, 1'b0, 16'h0000, LEVEL_RISING);
      send_request(REQ_TICK, 1'b0, 16'h5555, LEVEL_RISING);
      send_request(REQ_CAPTURE, 1'b0, 16'hF000, LEVEL_FALLING);
      send_request(REQ_CAPTURE, 1'b0, 16'h0010, LEVEL_RISING);
      send_request(REQ_CAPTURE, 1'b0, 16'h0011, LEVEL_RISING);
      send_request(REQ_CAPTURE, 1'b1, 16'hAAAA, LEVEL_FALLING);
      send_request(REQ_CAPTURE, 1'b1, 16'hAAAB, LEVEL_RISING);
      wait_drained();

      run_phase(32'd0, 16'd0, 200);
      run_phase(32'd300, 16'd3, 250);
      run_phase(32'hFFFF_FFFF, 16'hFFFF, 150);
      run_phase(TIME_W'($urandom_range(0, 2000)), LIMIT_W'($urandom_range(0, 6)), 250);
      run_phase(TIME_W'($urandom_range(60000, 140000)), 16'd4, 300);
      repeat (10) @(negedge clock);

      $display("%0d transactions in, %0d responses checked, %0d periods measured,",
               board.request_count, board.result_count, board.update_count);
      $display("%0d channel stops, across six register settings", board.stop_count);
      if (board.mismatch_count == 0 && board.pending() == 0)
         $display("dual_tacho_period_capture_unit: match");
      else
         $display("dual_tacho_period_capture_unit: mismatch");
      $finish;
   end

endmodule
